FILE: hdl/abld_pkg.sv
// Package for the analog ladder button decoder.
// Holds machine state codes, register indexes, reset values and a helper function.
// No dependencies.
`default_nettype none

package abld_pkg;

   localparam int unsigned SAMPLE_W = 8;
   localparam int unsigned STATE_W  = 3;
   localparam int unsigned CSR_IDX_W = 3;

   // machine state codes
   localparam logic [STATE_W-1:0] ST_IDLE  = 3'd0;
   localparam logic [STATE_W-1:0] ST_JOG   = 3'd1;
   localparam logic [STATE_W-1:0] ST_CYCLE = 3'd2;
   localparam logic [STATE_W-1:0] ST_HOLD  = 3'd3;
   localparam logic [STATE_W-1:0] ST_ALARM = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_JOG_LOW     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_JOG_HIGH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_KEY    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_KEY   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPINDLE_KEY = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MENU_KEY    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_HOME_KEY    = 3'd7;

   // register reset values
   localparam logic [SAMPLE_W-1:0] RST_JOG_LOW     = 8'd63;
   localparam logic [SAMPLE_W-1:0] RST_JOG_HIGH    = 8'd191;
   localparam logic [SAMPLE_W-1:0] RST_TOLERANCE   = 8'd2;
   localparam logic [SAMPLE_W-1:0] RST_STOP_KEY    = 8'd21;
   localparam logic [SAMPLE_W-1:0] RST_START_KEY   = 8'd58;
   localparam logic [SAMPLE_W-1:0] RST_SPINDLE_KEY = 8'd85;
   localparam logic [SAMPLE_W-1:0] RST_MENU_KEY    = 8'd105;
   localparam logic [SAMPLE_W-1:0] RST_HOME_KEY    = 8'd121;

   // feed override
   localparam logic [7:0] OVR_MIN   = 8'd50;
   localparam logic [7:0] OVR_MAX   = 8'd150;
   localparam logic [7:0] OVR_STEP  = 8'd5;
   localparam logic [7:0] OVR_RESET = 8'd100;

   // spindle commands
   localparam logic [1:0] SPIN_NONE = 2'd0;
   localparam logic [1:0] SPIN_MIN  = 2'd1;
   localparam logic [1:0] SPIN_OFF  = 2'd2;

   // button bit positions
   localparam int unsigned BIT_X_LOW   = 0;
   localparam int unsigned BIT_Y_LOW   = 1;
   localparam int unsigned BIT_X_HIGH  = 2;
   localparam int unsigned BIT_Y_HIGH  = 3;
   localparam int unsigned BIT_LATCH   = 4;
   localparam int unsigned BIT_MENU    = 5;
   localparam int unsigned BIT_START_M = 6;
   localparam int unsigned BIT_HOMING  = 7;

   function automatic logic [SAMPLE_W-1:0] abs_diff(input logic [SAMPLE_W-1:0] a,
                                                    input logic [SAMPLE_W-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

`default_nettype wire

FILE: hdl/analog_ladder_button_decoder_core.sv
// Top level of the analog ladder button decoder: input register, decode logic,
// result register, button state and configuration registers.
// Depends on abld_pkg.
//
//   channel  | ports     | direction | beat
//   ---------+-----------+-----------+-------------------------------------
//   request  | req_*     | in        | one scan of joystick and key samples
//   response | rsp_*     | out       | jog bits, override, requests
//   config   | csr_*     | in        | one register write, no handshake
//
// One beat per cycle while rsp_ready is high, through input and result register.
// The state update sits on the single path from input register to result register.
// Reset clears valid flags and button state, sets the override to 100 and reloads
// register defaults.
// With rsp_ready low the result holds, one more beat parks in the input register,
// then req_ready drops.
`default_nettype none

module analog_ladder_button_decoder_core (
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_jog_x_sample,
   input  wire logic [7:0] req_jog_y_sample,
   input  wire logic [7:0] req_key_sample_first,
   input  wire logic [7:0] req_key_sample_second,
   input  wire logic [7:0] req_key_sample_late,
   input  wire logic [2:0] req_machine_state,
   input  wire logic       req_homing_enabled,
   input  wire logic       req_spindle_is_off,
   input  wire logic       req_ack_requests,

   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [3:0]      rsp_jog_bits,
   output logic            rsp_override_held,
   output logic [7:0]      rsp_feed_override,
   output logic            rsp_replan_pulse,
   output logic            rsp_request_reset,
   output logic            rsp_request_feed_hold,
   output logic            rsp_request_cycle_start,
   output logic [1:0]      rsp_spindle_command,
   output logic [2:0]      rsp_pending_requests,

   input  wire logic       csr_write_enable,
   input  wire logic [2:0] csr_index,
   input  wire logic [7:0] csr_write_data
);

   // configuration
   logic [7:0] jog_low_ff, jog_high_ff, tol_ff;
   logic [7:0] stop_key_ff, start_key_ff, spindle_key_ff, menu_key_ff, home_key_ff;

   // input register
   logic       in_valid_ff;
   logic [7:0] x_ff, y_ff, k1_ff, k2_ff, kl_ff;
   logic [2:0] st_ff;
   logic       homing_ff, spin_off_ff, ack_ff;

   // block state
   logic [7:0] button_ff, button_in;
   logic       armed_ff, armed_in;
   logic [7:0] ovr_ff, ovr_in;

   // result register
   logic       out_valid_ff;
   logic [3:0] jog_ff;
   logic       held_ff;
   logic [7:0] feed_ff;
   logic       replan_ff, rst_ff, hold_ff, start_ff;
   logic       replan_in, rst_in, hold_in, start_in;
   logic [1:0] spin_ff, spin_in;
   logic [2:0] pend_ff;

   logic       advance;
   logic       jog_ok, ovr_ok, y_low, y_press, key_stable, conf;
   logic [8:0] ovr_up;
   logic [7:0] b;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         jog_low_ff     <= abld_pkg::RST_JOG_LOW;
         jog_high_ff    <= abld_pkg::RST_JOG_HIGH;
         tol_ff         <= abld_pkg::RST_TOLERANCE;
         stop_key_ff    <= abld_pkg::RST_STOP_KEY;
         start_key_ff   <= abld_pkg::RST_START_KEY;
         spindle_key_ff <= abld_pkg::RST_SPINDLE_KEY;
         menu_key_ff    <= abld_pkg::RST_MENU_KEY;
         home_key_ff    <= abld_pkg::RST_HOME_KEY;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            abld_pkg::CSR_JOG_LOW:     jog_low_ff     <= csr_write_data;
            abld_pkg::CSR_JOG_HIGH:    jog_high_ff    <= csr_write_data;
            abld_pkg::CSR_TOLERANCE:   tol_ff         <= csr_write_data;
            abld_pkg::CSR_STOP_KEY:    stop_key_ff    <= csr_write_data;
            abld_pkg::CSR_START_KEY:   start_key_ff   <= csr_write_data;
            abld_pkg::CSR_SPINDLE_KEY: spindle_key_ff <= csr_write_data;
            abld_pkg::CSR_MENU_KEY:    menu_key_ff    <= csr_write_data;
            abld_pkg::CSR_HOME_KEY:    home_key_ff    <= csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         x_ff        <= req_jog_x_sample;
         y_ff        <= req_jog_y_sample;
         k1_ff       <= req_key_sample_first;
         k2_ff       <= req_key_sample_second;
         kl_ff       <= req_key_sample_late;
         st_ff       <= req_machine_state;
         homing_ff   <= req_homing_enabled;
         spin_off_ff <= req_spindle_is_off;
         ack_ff      <= req_ack_requests;
      end
   end

   assign jog_ok     = (st_ff == abld_pkg::ST_IDLE) || (st_ff == abld_pkg::ST_JOG);
   assign ovr_ok     = (st_ff == abld_pkg::ST_CYCLE) || (st_ff == abld_pkg::ST_HOLD);
   assign y_low      = y_ff < jog_low_ff;
   assign y_press    = y_low || (y_ff < jog_high_ff);
   assign key_stable = abld_pkg::abs_diff(k1_ff, k2_ff) <= tol_ff;
   assign conf       = abld_pkg::abs_diff(kl_ff, k2_ff) <= tol_ff;
   assign ovr_up     = {1'b0, ovr_ff} + {1'b0, abld_pkg::OVR_STEP};

   always_comb begin
      b         = button_ff;
      armed_in  = armed_ff;
      ovr_in    = ovr_ff;
      replan_in = 1'b0;
      rst_in    = 1'b0;
      hold_in   = 1'b0;
      start_in  = 1'b0;
      spin_in   = abld_pkg::SPIN_NONE;

      if (ack_ff) begin
         b[7:5] = 3'b000;
      end

      if (x_ff < jog_low_ff) begin
         if (jog_ok) begin
            b[abld_pkg::BIT_X_HIGH] = 1'b0;
            b[abld_pkg::BIT_X_LOW]  = 1'b1;
         end
      end else if (x_ff < jog_high_ff) begin
         if (jog_ok) begin
            b[abld_pkg::BIT_X_LOW]  = 1'b0;
            b[abld_pkg::BIT_X_HIGH] = 1'b1;
         end
      end else begin
         b[abld_pkg::BIT_X_LOW]  = 1'b0;
         b[abld_pkg::BIT_X_HIGH] = 1'b0;
      end

      if (y_press) begin
         if (jog_ok) begin
            b[abld_pkg::BIT_Y_LOW]  = y_low;
            b[abld_pkg::BIT_Y_HIGH] = !y_low;
         end else if (ovr_ok && !b[abld_pkg::BIT_LATCH]) begin
            b[abld_pkg::BIT_LATCH] = 1'b1;
            if (y_low && (ovr_ff > abld_pkg::OVR_MIN)) begin
               ovr_in = (ovr_ff < (abld_pkg::OVR_MIN + abld_pkg::OVR_STEP)) ?
                        abld_pkg::OVR_MIN : (ovr_ff - abld_pkg::OVR_STEP);
               replan_in = 1'b1;
            end else if (!y_low && (ovr_ff < abld_pkg::OVR_MAX)) begin
               ovr_in = (ovr_up > {1'b0, abld_pkg::OVR_MAX}) ?
                        abld_pkg::OVR_MAX : ovr_up[7:0];
               replan_in = 1'b1;
            end
         end
      end else begin
         b[abld_pkg::BIT_Y_LOW]  = 1'b0;
         b[abld_pkg::BIT_Y_HIGH] = 1'b0;
         b[abld_pkg::BIT_LATCH]  = 1'b0;
      end

      if ((b == 8'd0) && key_stable) begin
         if (k2_ff < stop_key_ff) begin
            if (armed_ff) begin
               rst_in   = 1'b1;
               armed_in = 1'b0;
            end
         end else if (k2_ff < start_key_ff) begin
            if (armed_ff) begin
               if (st_ff == abld_pkg::ST_IDLE) begin
                  if (conf) begin
                     b[abld_pkg::BIT_START_M] = 1'b1;
                     armed_in = 1'b0;
                  end
               end else begin
                  hold_in  = (st_ff == abld_pkg::ST_CYCLE);
                  start_in = (st_ff == abld_pkg::ST_HOLD);
                  armed_in = 1'b0;
               end
            end
         end else if (k2_ff < spindle_key_ff) begin
            if (armed_ff) begin
               if (st_ff == abld_pkg::ST_IDLE) begin
                  if (conf) begin
                     spin_in  = spin_off_ff ? abld_pkg::SPIN_MIN : abld_pkg::SPIN_OFF;
                     armed_in = 1'b0;
                  end
               end else begin
                  armed_in = 1'b0;
               end
            end
         end else if (k2_ff < menu_key_ff) begin
            if (armed_ff) begin
               if (st_ff == abld_pkg::ST_IDLE) begin
                  if (conf) begin
                     b[abld_pkg::BIT_MENU] = 1'b1;
                     armed_in = 1'b0;
                  end
               end else begin
                  armed_in = 1'b0;
               end
            end
         end else if (k2_ff < home_key_ff) begin
            if (armed_ff) begin
               if (homing_ff && ((st_ff == abld_pkg::ST_IDLE) ||
                                 (st_ff == abld_pkg::ST_ALARM))) begin
                  if (conf) begin
                     b[abld_pkg::BIT_HOMING] = 1'b1;
                     armed_in = 1'b0;
                  end
               end else begin
                  armed_in = 1'b0;
               end
            end
         end else begin
            armed_in = 1'b1;
         end
      end

      button_in = b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         button_ff    <= 8'd0;
         armed_ff     <= 1'b0;
         ovr_ff       <= abld_pkg::OVR_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            button_ff <= button_in;
            armed_ff  <= armed_in;
            ovr_ff    <= ovr_in;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         jog_ff    <= button_in[3:0];
         held_ff   <= button_in[abld_pkg::BIT_LATCH];
         feed_ff   <= ovr_in;
         replan_ff <= replan_in;
         rst_ff    <= rst_in;
         hold_ff   <= hold_in;
         start_ff  <= start_in;
         spin_ff   <= spin_in;
         pend_ff   <= button_in[7:5];
      end
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_jog_bits            = jog_ff;
   assign rsp_override_held       = held_ff;
   assign rsp_feed_override       = feed_ff;
   assign rsp_replan_pulse        = replan_ff;
   assign rsp_request_reset       = rst_ff;
   assign rsp_request_feed_hold   = hold_ff;
   assign rsp_request_cycle_start = start_ff;
   assign rsp_spindle_command     = spin_ff;
   assign rsp_pending_requests    = pend_ff;

`ifndef SYNTH
   a_ovr_range: assert property (@(posedge clock) disable iff (reset)
      (ovr_ff >= abld_pkg::OVR_MIN) && (ovr_ff <= abld_pkg::OVR_MAX))
      else $error("feed override out of range");

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_request_reset, rsp_request_feed_hold,
                              rsp_request_cycle_start,
                              rsp_spindle_command != abld_pkg::SPIN_NONE}))
      else $error("more than one key action in one beat");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(x_ff) && $stable(k2_ff)))
      else $error("parked input beat lost");

   a_key_needs_free: assert property (@(posedge clock) disable iff (reset)
      (advance && (armed_in != armed_ff)) |-> (button_in[4:0] == 5'd0))
      else $error("key ladder acted while buttons held");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Testbench for analog_ladder_button_decoder_core: directed scans, a back-pressure
// burst and random scan sequences under several register settings, checked beat by
// beat against an in-bench decoder. Depends on abld_pkg and the core only.
`default_nettype none

module tb;

   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] k1;
      logic [7:0] k2;
      logic [7:0] kl;
      logic [2:0] st;
      logic       homing;
      logic       spin_off;
      logic       ack;
   } scan_type;

   typedef struct packed {
      logic [3:0] jog;
      logic       held;
      logic [7:0] feed;
      logic       replan;
      logic       rst;
      logic       hold;
      logic       start;
      logic [1:0] spin;
      logic [2:0] pending;
   } decode_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_jog_x_sample;
   logic [7:0] req_jog_y_sample;
   logic [7:0] req_key_sample_first;
   logic [7:0] req_key_sample_second;
   logic [7:0] req_key_sample_late;
   logic [2:0] req_machine_state;
   logic       req_homing_enabled;
   logic       req_spindle_is_off;
   logic       req_ack_requests;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [3:0] rsp_jog_bits;
   logic       rsp_override_held;
   logic [7:0] rsp_feed_override;
   logic       rsp_replan_pulse;
   logic       rsp_request_reset;
   logic       rsp_request_feed_hold;
   logic       rsp_request_cycle_start;
   logic [1:0] rsp_spindle_command;
   logic [2:0] rsp_pending_requests;
   logic       csr_write_enable;
   logic [2:0] csr_index;
   logic [7:0] csr_write_data;

   logic [7:0] limit_reg [8];
   logic [7:0] pred_buttons;
   logic       armed;
   logic [7:0] feed_pct;
   decode_type decode_q [$];
   int         mismatches;
   int         scans_sent;
   int         beats_seen;
   bit         idle_on;
   int         stall_request;

   analog_ladder_button_decoder_core u_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_jog_x_sample        (req_jog_x_sample),
      .req_jog_y_sample        (req_jog_y_sample),
      .req_key_sample_first    (req_key_sample_first),
      .req_key_sample_second   (req_key_sample_second),
      .req_key_sample_late     (req_key_sample_late),
      .req_machine_state       (req_machine_state),
      .req_homing_enabled      (req_homing_enabled),
      .req_spindle_is_off      (req_spindle_is_off),
      .req_ack_requests        (req_ack_requests),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_jog_bits            (rsp_jog_bits),
      .rsp_override_held       (rsp_override_held),
      .rsp_feed_override       (rsp_feed_override),
      .rsp_replan_pulse        (rsp_replan_pulse),
      .rsp_request_reset       (rsp_request_reset),
      .rsp_request_feed_hold   (rsp_request_feed_hold),
      .rsp_request_cycle_start (rsp_request_cycle_start),
      .rsp_spindle_command     (rsp_spindle_command),
      .rsp_pending_requests    (rsp_pending_requests),
      .csr_write_enable        (csr_write_enable),
      .csr_index               (csr_index),
      .csr_write_data          (csr_write_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [7:0] key_gap(logic [7:0] a, logic [7:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic decode_type decode_scan(scan_type s);
      decode_type r;
      logic [7:0] b;
      logic [7:0] o;
      logic [7:0] v;
      logic [7:0] tol;
      logic       jog_ok;
      logic       ovr_ok;
      logic       low;
      logic       conf;
      r = '0;
      b = pred_buttons;
      tol = limit_reg[abld_pkg::CSR_TOLERANCE];
      jog_ok = (s.st == abld_pkg::ST_IDLE) || (s.st == abld_pkg::ST_JOG);
      ovr_ok = (s.st == abld_pkg::ST_CYCLE) || (s.st == abld_pkg::ST_HOLD);
      if (s.ack) begin
         b[abld_pkg::BIT_MENU] = 1'b0;
         b[abld_pkg::BIT_START_M] = 1'b0;
         b[abld_pkg::BIT_HOMING] = 1'b0;
      end
      if (s.x < limit_reg[abld_pkg::CSR_JOG_LOW]) begin
         if (jog_ok) begin
            b[abld_pkg::BIT_X_HIGH] = 1'b0;
            b[abld_pkg::BIT_X_LOW] = 1'b1;
         end
      end else if (s.x < limit_reg[abld_pkg::CSR_JOG_HIGH]) begin
         if (jog_ok) begin
            b[abld_pkg::BIT_X_LOW] = 1'b0;
            b[abld_pkg::BIT_X_HIGH] = 1'b1;
         end
      end else begin
         b[abld_pkg::BIT_X_LOW] = 1'b0;
         b[abld_pkg::BIT_X_HIGH] = 1'b0;
      end
      if (s.y < limit_reg[abld_pkg::CSR_JOG_LOW] ||
          s.y < limit_reg[abld_pkg::CSR_JOG_HIGH]) begin
         low = s.y < limit_reg[abld_pkg::CSR_JOG_LOW];
         if (jog_ok) begin
            b[abld_pkg::BIT_Y_LOW] = low;
            b[abld_pkg::BIT_Y_HIGH] = !low;
         end else if (ovr_ok && !b[abld_pkg::BIT_LATCH]) begin
            b[abld_pkg::BIT_LATCH] = 1'b1;
            o = feed_pct;
            if (low && o > abld_pkg::OVR_MIN) begin
               o = (o < abld_pkg::OVR_MIN + abld_pkg::OVR_STEP) ?
                   abld_pkg::OVR_MIN : o - abld_pkg::OVR_STEP;
               r.replan = 1'b1;
            end else if (!low && o < abld_pkg::OVR_MAX) begin
               o = (o + abld_pkg::OVR_STEP > abld_pkg::OVR_MAX) ?
                   abld_pkg::OVR_MAX : o + abld_pkg::OVR_STEP;
               r.replan = 1'b1;
            end
            feed_pct = o;
         end
      end else begin
         b[abld_pkg::BIT_Y_LOW] = 1'b0;
         b[abld_pkg::BIT_Y_HIGH] = 1'b0;
         b[abld_pkg::BIT_LATCH] = 1'b0;
      end
      if (b == 8'd0 && key_gap(s.k1, s.k2) <= tol) begin
         v = s.k2;
         conf = key_gap(s.kl, v) <= tol;
         if (v < limit_reg[abld_pkg::CSR_STOP_KEY]) begin
            if (armed) begin
               r.rst = 1'b1;
               armed = 1'b0;
            end
         end else if (v < limit_reg[abld_pkg::CSR_START_KEY]) begin
            if (armed) begin
               if (s.st == abld_pkg::ST_IDLE) begin
                  if (conf) begin
                     b[abld_pkg::BIT_START_M] = 1'b1;
                     armed = 1'b0;
                  end
               end else begin
                  r.hold = (s.st == abld_pkg::ST_CYCLE);
                  r.start = (s.st == abld_pkg::ST_HOLD);
                  armed = 1'b0;
               end
            end
         end else if (v < limit_reg[abld_pkg::CSR_SPINDLE_KEY]) begin
            if (armed) begin
               if (s.st == abld_pkg::ST_IDLE) begin
                  if (conf) begin
                     r.spin = s.spin_off ? abld_pkg::SPIN_MIN : abld_pkg::SPIN_OFF;
                     armed = 1'b0;
                  end
               end else begin
                  armed = 1'b0;
               end
            end
         end else if (v < limit_reg[abld_pkg::CSR_MENU_KEY]) begin
            if (armed) begin
               if (s.st == abld_pkg::ST_IDLE) begin
                  if (conf) begin
                     b[abld_pkg::BIT_MENU] = 1'b1;
                     armed = 1'b0;
                  end
               end else begin
                  armed = 1'b0;
               end
            end
         end else if (v < limit_reg[abld_pkg::CSR_HOME_KEY]) begin
            if (armed) begin
               if (s.homing && (s.st == abld_pkg::ST_IDLE ||
                                s.st == abld_pkg::ST_ALARM)) begin
                  if (conf) begin
                     b[abld_pkg::BIT_HOMING] = 1'b1;
                     armed = 1'b0;
                  end
               end else begin
                  armed = 1'b0;
               end
            end
         end else begin
            armed = 1'b1;
         end
      end
      pred_buttons = b;
      r.jog = b[3:0];
      r.held = b[abld_pkg::BIT_LATCH];
      r.feed = feed_pct;
      r.pending = b[7:5];
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH beat %0d: %s", beats_seen, msg);
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   always @(posedge clock) begin : check_beat
      decode_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decode_q.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            want = decode_q.pop_front();
            check_field("jog_bits", int'(rsp_jog_bits), int'(want.jog));
            check_field("override_held", int'(rsp_override_held), int'(want.held));
            check_field("feed_override", int'(rsp_feed_override), int'(want.feed));
            check_field("replan_pulse", int'(rsp_replan_pulse), int'(want.replan));
            check_field("request_reset", int'(rsp_request_reset), int'(want.rst));
            check_field("request_feed_hold", int'(rsp_request_feed_hold),
                        int'(want.hold));
            check_field("request_cycle_start", int'(rsp_request_cycle_start),
                        int'(want.start));
            check_field("spindle_command", int'(rsp_spindle_command), int'(want.spin));
            check_field("pending_requests", int'(rsp_pending_requests),
                        int'(want.pending));
         end
         beats_seen++;
      end
   end

   initial begin : result_sink
      int w;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (stall_request > 0) begin
            w = stall_request;
            stall_request = 0;
         end else begin
            w = idle_on ? int'($urandom_range(0, 10)) : 0;
         end
         if (w > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (w - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_scan(scan_type s);
      int gap;
      gap = idle_on ? int'($urandom_range(0, 10)) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_jog_x_sample <= s.x;
      req_jog_y_sample <= s.y;
      req_key_sample_first <= s.k1;
      req_key_sample_second <= s.k2;
      req_key_sample_late <= s.kl;
      req_machine_state <= s.st;
      req_homing_enabled <= s.homing;
      req_spindle_is_off <= s.spin_off;
      req_ack_requests <= s.ack;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_q.push_back(decode_scan(s));
      scans_sent++;
   endtask

   task automatic drain_decoder();
      @(negedge clock);
      req_valid <= 1'b0;
      while (decode_q.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(logic [2:0] idx, logic [7:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      limit_reg[idx] = val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic apply_limits(int lo, int hi, int tol, int stop, int start,
                               int spin, int menu, int home);
      drain_decoder();
      write_limit(abld_pkg::CSR_JOG_LOW, 8'(lo));
      write_limit(abld_pkg::CSR_JOG_HIGH, 8'(hi));
      write_limit(abld_pkg::CSR_TOLERANCE, 8'(tol));
      write_limit(abld_pkg::CSR_STOP_KEY, 8'(stop));
      write_limit(abld_pkg::CSR_START_KEY, 8'(start));
      write_limit(abld_pkg::CSR_SPINDLE_KEY, 8'(spin));
      write_limit(abld_pkg::CSR_MENU_KEY, 8'(menu));
      write_limit(abld_pkg::CSR_HOME_KEY, 8'(home));
   endtask

   function automatic scan_type mk_scan(int x, int y, int k1, int k2, int kl, int st,
                                        int homing, int spin_off, int ack);
      scan_type s;
      s.x = 8'(x);
      s.y = 8'(y);
      s.k1 = 8'(k1);
      s.k2 = 8'(k2);
      s.kl = 8'(kl);
      s.st = 3'(st);
      s.homing = 1'(homing);
      s.spin_off = 1'(spin_off);
      s.ack = 1'(ack);
      return s;
   endfunction

   function automatic scan_type rand_scan();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return scan_type'(r[$bits(scan_type)-1:0]);
   endfunction

   function automatic logic [7:0] near_sample(int v, int spread);
      int n;
      n = v + int'($urandom_range(0, 2 * spread)) - spread;
      if (n < 0) n = 0;
      if (n > 255) n = 255;
      return 8'(n);
   endfunction

   function automatic logic [7:0] neutral_sample();
      logic [7:0] top;
      top = (limit_reg[abld_pkg::CSR_JOG_LOW] > limit_reg[abld_pkg::CSR_JOG_HIGH]) ?
            limit_reg[abld_pkg::CSR_JOG_LOW] : limit_reg[abld_pkg::CSR_JOG_HIGH];
      return 8'($urandom_range(255, top));
   endfunction

   function automatic logic [7:0] band_sample(int lo, int hi);
      if (hi < lo) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(hi, lo));
   endfunction

   function automatic logic [7:0] key_in_band(int band);
      int         lo;
      int         hi;
      logic [2:0] lo_idx;
      logic [2:0] hi_idx;
      lo_idx = 3'(int'(abld_pkg::CSR_STOP_KEY) + band - 1);
      hi_idx = 3'(int'(abld_pkg::CSR_STOP_KEY) + band);
      lo = (band == 0) ? 0 : int'(limit_reg[lo_idx]);
      hi = (band == 5) ? 255 : int'(limit_reg[hi_idx]) - 1;
      return band_sample(lo, hi);
   endfunction

   function automatic scan_type quiet_scan(int band);
      scan_type s;
      int       tol;
      tol = int'(limit_reg[abld_pkg::CSR_TOLERANCE]);
      s.x = neutral_sample();
      s.y = neutral_sample();
      s.k2 = key_in_band(band);
      s.k1 = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
             near_sample(int'(s.k2), tol);
      s.kl = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
             near_sample(int'(s.k2), tol);
      s.st = ($urandom_range(0, 1) == 0) ? abld_pkg::ST_IDLE : 3'($urandom_range(0, 7));
      s.homing = ($urandom_range(0, 3) != 0);
      s.spin_off = 1'($urandom_range(0, 1));
      s.ack = 1'b0;
      return s;
   endfunction

   task automatic key_sequence();
      scan_type s;
      s = quiet_scan(5);
      s.ack = 1'($urandom_range(0, 1));
      send_scan(s);
      s = quiet_scan(int'($urandom_range(0, 4)));
      s.ack = ($urandom_range(0, 7) == 0);
      send_scan(s);
   endtask

   task automatic feed_sequence();
      scan_type s;
      logic     low;
      int       reps;
      reps = int'($urandom_range(3, 14));
      low = 1'($urandom_range(0, 1));
      s = quiet_scan(int'($urandom_range(0, 5)));
      s.st = ($urandom_range(0, 1) != 0) ? abld_pkg::ST_CYCLE : abld_pkg::ST_HOLD;
      repeat (reps) begin
         if (low)
            s.y = band_sample(0, int'(limit_reg[abld_pkg::CSR_JOG_LOW]) - 1);
         else
            s.y = band_sample(int'(limit_reg[abld_pkg::CSR_JOG_LOW]),
                              int'(limit_reg[abld_pkg::CSR_JOG_HIGH]) - 1);
         s.x = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
               neutral_sample();
         send_scan(s);
         s.y = neutral_sample();
         send_scan(s);
      end
   endtask

   task automatic jog_sequence();
      scan_type s;
      repeat ($urandom_range(2, 5)) begin
         s = quiet_scan(5);
         s.st = ($urandom_range(0, 1) != 0) ? abld_pkg::ST_IDLE : abld_pkg::ST_JOG;
         s.x = 8'($urandom_range(0, 255));
         s.y = 8'($urandom_range(0, 255));
         send_scan(s);
      end
   endtask

   task automatic run_random(int n);
      int first;
      int next_flip;
      int kind;
      first = scans_sent;
      next_flip = scans_sent;
      while (scans_sent - first < n) begin
         if (scans_sent >= next_flip) begin
            idle_on = ($urandom_range(0, 2) != 0);
            next_flip = scans_sent + int'($urandom_range(20, 60));
         end
         kind = int'($urandom_range(0, 9));
         if (kind < 4)
            key_sequence();
         else if (kind < 6)
            feed_sequence();
         else if (kind < 8)
            jog_sequence();
         else
            send_scan(rand_scan());
      end
   endtask

   task automatic test_directed();
      int idle;
      int cyc;
      int hld;
      int alm;
      int jog;
      idle = int'(abld_pkg::ST_IDLE);
      cyc = int'(abld_pkg::ST_CYCLE);
      hld = int'(abld_pkg::ST_HOLD);
      alm = int'(abld_pkg::ST_ALARM);
      jog = int'(abld_pkg::ST_JOG);
      idle_on = 1'b1;
      send_scan(mk_scan(0, 0, 255, 255, 255, idle, 0, 0, 0));
      send_scan(mk_scan(255, 255, 200, 200, 200, idle, 0, 0, 0));
      send_scan(mk_scan(255, 255, 10, 10, 10, idle, 0, 0, 0));
      send_scan(mk_scan(255, 255, 200, 201, 0, idle, 0, 0, 0));
      send_scan(mk_scan(255, 255, 40, 40, 40, cyc, 0, 0, 0));
      send_scan(mk_scan(255, 255, 200, 200, 200, idle, 0, 0, 0));
      send_scan(mk_scan(255, 255, 40, 42, 42, hld, 0, 0, 0));
      send_scan(mk_scan(255, 255, 200, 200, 200, idle, 0, 0, 0));
      send_scan(mk_scan(255, 255, 40, 40, 41, idle, 0, 0, 0));
      send_scan(mk_scan(255, 255, 200, 200, 200, idle, 0, 0, 0));
      send_scan(mk_scan(255, 255, 200, 200, 200, idle, 0, 0, 1));
      send_scan(mk_scan(255, 255, 70, 70, 70, idle, 0, 1, 0));
      send_scan(mk_scan(255, 255, 200, 200, 200, idle, 0, 0, 0));
      send_scan(mk_scan(255, 255, 70, 70, 0, idle, 0, 0, 0));
      send_scan(mk_scan(255, 255, 70, 70, 72, idle, 0, 0, 0));
      send_scan(mk_scan(255, 255, 200, 200, 200, idle, 0, 0, 0));
      send_scan(mk_scan(255, 255, 95, 95, 95, idle, 1, 0, 0));
      send_scan(mk_scan(255, 255, 200, 200, 200, idle, 0, 0, 1));
      send_scan(mk_scan(255, 255, 110, 110, 110, alm, 1, 0, 0));
      send_scan(mk_scan(255, 255, 200, 200, 200, idle, 0, 0, 1));
      send_scan(mk_scan(255, 255, 0, 110, 110, idle, 1, 0, 0));
      send_scan(mk_scan(255, 255, 110, 110, 110, idle, 0, 0, 0));
      send_scan(mk_scan(0, 100, 255, 255, 255, 7, 1, 1, 1));
      send_scan(mk_scan(255, 100, 255, 255, 255, cyc, 0, 0, 0));
      send_scan(mk_scan(255, 100, 255, 255, 255, hld, 0, 0, 0));
      send_scan(mk_scan(255, 0, 255, 255, 255, cyc, 0, 0, 0));
      send_scan(mk_scan(255, 255, 255, 255, 255, hld, 0, 0, 0));
      send_scan(mk_scan(128, 128, 128, 128, 128, 6, 0, 0, 0));
      send_scan(mk_scan(128, 128, 128, 128, 128, jog, 0, 0, 0));
   endtask

   task automatic test_backpressure();
      drain_decoder();
      idle_on = 1'b0;
      stall_request = 80;
      repeat (30) send_scan(rand_scan());
   endtask

   task automatic test_random_defaults();
      run_random(170);
   endtask

   task automatic test_random_wide();
      apply_limits(0, 255, 0, 30, 60, 90, 120, 150);
      run_random(160);
   endtask

   task automatic test_random_top();
      apply_limits(255, 255, 255, 255, 255, 255, 255, 255);
      run_random(150);
   endtask

   task automatic test_random_zero();
      apply_limits(0, 0, 0, 0, 0, 0, 0, 0);
      run_random(150);
   endtask

   task automatic test_random_sorted();
      int q [$];
      repeat (5) q.push_back(int'($urandom_range(0, 255)));
      q.sort();
      apply_limits(int'($urandom_range(0, 127)), int'($urandom_range(128, 255)),
                   int'($urandom_range(0, 8)), q[0], q[1], q[2], q[3], q[4]);
      run_random(180);
   endtask

   task automatic test_random_scrambled();
      apply_limits(int'($urandom_range(0, 255)), int'($urandom_range(0, 255)),
                   int'($urandom_range(0, 255)), int'($urandom_range(0, 255)),
                   int'($urandom_range(0, 255)), int'($urandom_range(0, 255)),
                   int'($urandom_range(0, 255)), int'($urandom_range(0, 255)));
      run_random(160);
   endtask

   task automatic test_random_restored();
      apply_limits(int'(abld_pkg::RST_JOG_LOW), int'(abld_pkg::RST_JOG_HIGH),
                   int'(abld_pkg::RST_TOLERANCE), int'(abld_pkg::RST_STOP_KEY),
                   int'(abld_pkg::RST_START_KEY), int'(abld_pkg::RST_SPINDLE_KEY),
                   int'(abld_pkg::RST_MENU_KEY), int'(abld_pkg::RST_HOME_KEY));
      run_random(170);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_jog_x_sample = '0;
      req_jog_y_sample = '0;
      req_key_sample_first = '0;
      req_key_sample_second = '0;
      req_key_sample_late = '0;
      req_machine_state = abld_pkg::ST_IDLE;
      req_homing_enabled = 1'b0;
      req_spindle_is_off = 1'b0;
      req_ack_requests = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = abld_pkg::CSR_JOG_LOW;
      csr_write_data = '0;
      limit_reg[abld_pkg::CSR_JOG_LOW] = abld_pkg::RST_JOG_LOW;
      limit_reg[abld_pkg::CSR_JOG_HIGH] = abld_pkg::RST_JOG_HIGH;
      limit_reg[abld_pkg::CSR_TOLERANCE] = abld_pkg::RST_TOLERANCE;
      limit_reg[abld_pkg::CSR_STOP_KEY] = abld_pkg::RST_STOP_KEY;
      limit_reg[abld_pkg::CSR_START_KEY] = abld_pkg::RST_START_KEY;
      limit_reg[abld_pkg::CSR_SPINDLE_KEY] = abld_pkg::RST_SPINDLE_KEY;
      limit_reg[abld_pkg::CSR_MENU_KEY] = abld_pkg::RST_MENU_KEY;
      limit_reg[abld_pkg::CSR_HOME_KEY] = abld_pkg::RST_HOME_KEY;
      pred_buttons = '0;
      armed = 1'b0;
      feed_pct = abld_pkg::OVR_RESET;
      mismatches = 0;
      scans_sent = 0;
      beats_seen = 0;
      idle_on = 1'b1;
      stall_request = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_backpressure();
      test_random_defaults();
      test_random_wide();
      test_random_top();
      test_random_zero();
      test_random_sorted();
      test_random_scrambled();
      test_random_restored();

      @(negedge clock);
      req_valid <= 1'b0;
      while (decode_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && decode_q.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #3000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
